// ===== rtl/core/prmt_pkg.sv =====
// Package for the pending response match table.
// Holds the widths, command and event codes, the queued item and result types
// and the slot search helpers. Depends on nothing.
`default_nettype none

package prmt_pkg;

    localparam int SLOTS       = 8;
    localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int MAX_RES     = 8;
    localparam int RES_CNT_W   = $clog2(MAX_RES);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CMD_W       = 2;
    localparam int HANDLE_W    = 8;
    localparam int SEQ_W       = 16;
    localparam int TYPE_W      = 8;
    localparam int REMOTE_W    = 16;
    localparam int TIME_W      = 32;
    localparam int EVENT_W     = 4;
    localparam int OUT_SLOT_W  = 3;
    localparam int REMOVED_W   = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [TIME_W-1:0] PERIOD_RESET = 32'd1000;
    localparam logic [TYPE_W-1:0] NACK_RESET   = 8'd255;
    localparam logic [REMOVED_W-1:0] REMOVED_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_NACK   = 2'd1;

    localparam logic [CMD_W-1:0] CMD_REGISTER   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RESPONSE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK       = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNREGISTER = 2'd3;

    typedef enum logic [1:0] {
        OP_REG,
        OP_RESP,
        OP_TICK,
        OP_UNREG
    } t_op;

    typedef enum logic [EVENT_W-1:0] {
        EV_REG_OK      = 4'd0,
        EV_REG_REFUSED = 4'd1,
        EV_DELIVER     = 4'd2,
        EV_NACK_FAIL   = 4'd3,
        EV_TIMEOUT     = 4'd4,
        EV_NO_MATCH    = 4'd5,
        EV_UNREG_DONE  = 4'd6,
        EV_UNREG_NONE  = 4'd7,
        EV_TICK_DONE   = 4'd8
    } t_event;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef struct packed {
        t_op                 op;
        logic [HANDLE_W-1:0] handle;
        logic [SEQ_W-1:0]    seq;
        logic [TYPE_W-1:0]   ptype;
        logic [REMOTE_W-1:0] remote;
        logic [TIME_W-1:0]   deadline;
        logic [TIME_W-1:0]   now;
    } t_item;

    typedef struct packed {
        t_event                event_res;
        logic [HANDLE_W-1:0]   handle;
        logic [SEQ_W-1:0]      seq;
        logic [REMOTE_W-1:0]   remote;
        logic [OUT_SLOT_W-1:0] slot;
        logic [REMOVED_W-1:0]  removed;
        logic                  last;
    } t_result;

    function automatic logic [SLOT_W-1:0] lowest_set(input logic [SLOTS-1:0] vec);
        logic [SLOT_W-1:0] idx;
        idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (vec[i]) begin
                idx = SLOT_W'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [OUT_SLOT_W-1:0] slot_code(input logic [SLOT_W-1:0] idx);
        logic [SLOT_W+OUT_SLOT_W-1:0] ext;
        ext = (SLOT_W + OUT_SLOT_W)'(idx);
        return ext[OUT_SLOT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pending_response_match_table_unit.sv =====
// Pending response match table: eight listener slots matched against register,
// response, tick and unregister commands. An item passes an input register and
// a two-beat queue; the slot sequencer registers its slot mask on taking it,
// then emits one result beat per cycle while the output does not stall, at most
// 8 per item, and takes no new item until the last beat; it sets the rate. Beats
// leave through an output register; the input side keeps taking items into the
// queue while results wait, until full. Config writes are taken every cycle.
// Top level; instantiates prmt_front, prmt_queue and prmt_back, uses prmt_pkg.
`default_nettype none

module pending_response_match_table_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [prmt_pkg::CMD_W-1:0]      i_cmd,
    input  wire logic [prmt_pkg::HANDLE_W-1:0]   i_owner_handle,
    input  wire logic [prmt_pkg::SEQ_W-1:0]      i_seq_num,
    input  wire logic [prmt_pkg::TYPE_W-1:0]     i_pkt_type,
    input  wire logic [prmt_pkg::REMOTE_W-1:0]   i_remote_addr,
    input  wire logic [prmt_pkg::TIME_W-1:0]     i_deadline,
    input  wire logic [prmt_pkg::TIME_W-1:0]     i_now_time,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [prmt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [prmt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [prmt_pkg::EVENT_W-1:0]         o_event_res,
    output logic [prmt_pkg::HANDLE_W-1:0]        o_out_handle,
    output logic [prmt_pkg::SEQ_W-1:0]           o_out_seq,
    output logic [prmt_pkg::REMOTE_W-1:0]        o_out_remote,
    output logic [prmt_pkg::OUT_SLOT_W-1:0]      o_out_slot,
    output logic [prmt_pkg::REMOVED_W-1:0]       o_removed_count,
    output logic                                 o_last
);
    import prmt_pkg::*;

    logic    q_full, push, pop, head_valid;
    t_item   push_item, head;
    t_result result;

    prmt_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_owner_handle (i_owner_handle),
        .i_seq_num      (i_seq_num),
        .i_pkt_type     (i_pkt_type),
        .i_remote_addr  (i_remote_addr),
        .i_deadline     (i_deadline),
        .i_now_time     (i_now_time),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_item         (push_item)
    );

    prmt_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_item       (push_item),
        .o_full       (q_full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    prmt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_result     (result)
    );

    assign o_event_res     = result.event_res;
    assign o_out_handle    = result.handle;
    assign o_out_seq       = result.seq;
    assign o_out_remote    = result.remote;
    assign o_out_slot      = result.slot;
    assign o_removed_count = result.removed;
    assign o_last          = result.last;

endmodule

`default_nettype wire

// ===== rtl/core/prmt_front.sv =====
// Front end of the pending response match table: input beat register and
// command decode into a queued item. Depends on prmt_pkg.
`default_nettype none

module prmt_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [prmt_pkg::CMD_W-1:0]    i_cmd,
    input  wire logic [prmt_pkg::HANDLE_W-1:0] i_owner_handle,
    input  wire logic [prmt_pkg::SEQ_W-1:0]    i_seq_num,
    input  wire logic [prmt_pkg::TYPE_W-1:0]   i_pkt_type,
    input  wire logic [prmt_pkg::REMOTE_W-1:0] i_remote_addr,
    input  wire logic [prmt_pkg::TIME_W-1:0]   i_deadline,
    input  wire logic [prmt_pkg::TIME_W-1:0]   i_now_time,
    input  wire logic                          i_q_full,
    output logic                               o_push,
    output prmt_pkg::t_item                    o_item
);
    import prmt_pkg::*;

    logic  r_valid, n_valid;
    t_item r_item, n_item;
    logic  accept;

    assign o_in_stall = r_valid && i_q_full;
    assign o_push     = r_valid && !i_q_full;
    assign o_item     = r_item;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_valid = r_valid;
        n_item  = r_item;
        if (accept) begin
            n_valid        = 1'b1;
            n_item.handle  = i_owner_handle;
            n_item.seq     = i_seq_num;
            n_item.ptype   = i_pkt_type;
            n_item.remote  = i_remote_addr;
            n_item.deadline = i_deadline;
            n_item.now     = i_now_time;
            unique case (i_cmd)
                CMD_REGISTER:   n_item.op = OP_REG;
                CMD_RESPONSE:   n_item.op = OP_RESP;
                CMD_TICK:       n_item.op = OP_TICK;
                CMD_UNREGISTER: n_item.op = OP_UNREG;
                default:        n_item.op = OP_UNREG;
            endcase
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_item <= n_item;
    end

endmodule

`default_nettype wire

// ===== rtl/core/prmt_queue.sv =====
// Short item queue between the front end and the slot sequencer.
// Depends on prmt_pkg for the item type and depth.
`default_nettype none

module prmt_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire prmt_pkg::t_item i_item,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_head_valid,
    output prmt_pkg::t_item      o_head
);
    import prmt_pkg::*;

    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr, n_wr;
    logic [QPTR_W-1:0]  r_rd, n_rd;
    logic [QCNT_W-1:0]  r_cnt, n_cnt;
    logic               do_push, do_pop;

    assign o_full       = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rd];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && o_head_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/prmt_back.sv =====
// Slot sequencer of the pending response match table: slot storage, config
// registers, per-item slot mask, one result beat per unstalled cycle. Uses prmt_pkg.
`default_nettype none

module prmt_back (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_head_valid,
    input  wire prmt_pkg::t_item                 i_head,
    output logic                                 o_pop,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [prmt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [prmt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output prmt_pkg::t_result                    o_result
);
    import prmt_pkg::*;

    logic [HANDLE_W-1:0] r_owner    [SLOTS];
    logic [SEQ_W-1:0]    r_seq      [SLOTS];
    logic [TYPE_W-1:0]   r_type     [SLOTS];
    logic [REMOTE_W-1:0] r_remote   [SLOTS];
    logic [TIME_W-1:0]   r_deadline [SLOTS];

    logic [TIME_W-1:0]    r_period;
    logic [TYPE_W-1:0]    r_nack;
    logic [TIME_W-1:0]    r_last_sweep, n_last_sweep;
    t_state               r_state, n_state;
    t_item                r_item, n_item;
    logic [SLOTS-1:0]     r_mask, n_mask;
    logic                 r_is_nack, n_is_nack;
    logic [RES_CNT_W-1:0] r_res_cnt, n_res_cnt;
    logic                 r_out_valid, n_out_valid;
    t_result              r_out, n_out;

    logic [SLOTS-1:0]     valid_vec, free_vec, head_mask, clear_vec;
    logic                 sweep_ok;
    logic [SLOT_W-1:0]    idx;
    logic [SLOTS-1:0]     idx_hot, rest;
    logic                 emit, step_last, do_write;
    logic [CNT_W-1:0]     rm_cnt;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            valid_vec[i] = (r_owner[i] != '0);
        end
        free_vec = ~valid_vec;
        sweep_ok = (|valid_vec) && (i_head.now > r_period)
                   && ((i_head.now - r_last_sweep) > r_period);
        head_mask = '0;
        unique case (i_head.op)
            OP_REG: begin
                if (i_head.handle != '0 && |free_vec) begin
                    head_mask = SLOTS'(1) << lowest_set(free_vec);
                end
            end
            OP_RESP: begin
                for (int i = 0; i < SLOTS; i++) begin
                    head_mask[i] = valid_vec[i]
                        && (r_type[i] == i_head.ptype || r_seq[i] == i_head.seq)
                        && (r_remote[i] == i_head.remote || r_remote[i] == '0);
                end
            end
            OP_TICK: begin
                for (int i = 0; i < SLOTS; i++) begin
                    head_mask[i] = sweep_ok && valid_vec[i] && r_deadline[i] != '0
                        && r_deadline[i] < i_head.now;
                end
            end
            OP_UNREG: begin
                for (int i = 0; i < SLOTS; i++) begin
                    head_mask[i] = (i_head.handle != '0) && (r_owner[i] == i_head.handle);
                end
            end
            default: head_mask = '0;
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_mask       = r_mask;
        n_is_nack    = r_is_nack;
        n_res_cnt    = r_res_cnt;
        n_last_sweep = r_last_sweep;
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        o_pop        = 1'b0;
        emit         = 1'b0;
        do_write     = 1'b0;
        clear_vec    = '0;
        idx          = lowest_set(r_mask);
        idx_hot      = SLOTS'(1) << idx;
        rest         = r_mask & ~idx_hot;
        rm_cnt       = CNT_W'($countones(r_mask));
        step_last    = (rest == '0) || (r_res_cnt == RES_CNT_W'(MAX_RES - 1));

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_head_valid) begin
                    o_pop     = 1'b1;
                    n_item    = i_head;
                    n_mask    = head_mask;
                    n_is_nack = (i_head.ptype == r_nack);
                    n_res_cnt = '0;
                    if (i_head.op == OP_TICK && sweep_ok) begin
                        n_last_sweep = i_head.now;
                    end
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (!r_out_valid || !i_out_stall) begin
                    emit        = 1'b1;
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    n_out.last  = 1'b1;
                    unique case (r_item.op)
                        OP_REG: begin
                            n_out.handle = r_item.handle;
                            if (r_mask == '0) begin
                                n_out.event_res = EV_REG_REFUSED;
                            end else begin
                                n_out.event_res = EV_REG_OK;
                                n_out.slot      = slot_code(idx);
                                do_write        = 1'b1;
                            end
                        end
                        OP_RESP: begin
                            if (r_mask == '0) begin
                                n_out.event_res = EV_NO_MATCH;
                            end else begin
                                n_out.event_res = r_is_nack ? EV_NACK_FAIL : EV_DELIVER;
                                n_out.handle    = r_owner[idx];
                                n_out.seq       = r_item.seq;
                                n_out.remote    = r_item.remote;
                                n_out.slot      = slot_code(idx);
                                n_out.last      = step_last;
                            end
                        end
                        OP_TICK: begin
                            if (r_mask == '0) begin
                                n_out.event_res = EV_TICK_DONE;
                            end else begin
                                n_out.event_res = EV_TIMEOUT;
                                n_out.handle    = r_owner[idx];
                                n_out.seq       = r_seq[idx];
                                n_out.remote    = r_remote[idx];
                                n_out.slot      = slot_code(idx);
                                n_out.last      = step_last;
                                clear_vec       = step_last ? r_mask : idx_hot;
                            end
                        end
                        OP_UNREG: begin
                            n_out.handle    = r_item.handle;
                            n_out.event_res = (r_mask != '0) ? EV_UNREG_DONE : EV_UNREG_NONE;
                            n_out.removed   = (rm_cnt > CNT_W'(REMOVED_MAX)) ? REMOVED_MAX
                                                                              : REMOVED_W'(rm_cnt);
                            clear_vec       = r_mask;
                        end
                        default: n_out.event_res = EV_NO_MATCH;
                    endcase
                    n_mask    = rest;
                    n_res_cnt = r_res_cnt + 1'b1;
                    if (n_out.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_period     <= PERIOD_RESET;
            r_nack       <= NACK_RESET;
            r_last_sweep <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                r_owner[i] <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_last_sweep <= n_last_sweep;
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_IDX_PERIOD) begin
                    r_period <= i_cfg_data;
                end else if (i_cfg_index == CFG_IDX_NACK) begin
                    r_nack <= i_cfg_data[TYPE_W-1:0];
                end
            end
            for (int i = 0; i < SLOTS; i++) begin
                if (emit && clear_vec[i]) begin
                    r_owner[i] <= '0;
                end
            end
            if (do_write) begin
                r_owner[idx] <= r_item.handle;
            end
        end
        if (do_write) begin
            r_seq[idx]      <= r_item.seq;
            r_type[idx]     <= r_item.ptype;
            r_remote[idx]   <= r_item.remote;
            r_deadline[idx] <= r_item.deadline;
        end
        r_item    <= n_item;
        r_mask    <= n_mask;
        r_is_nack <= n_is_nack;
        r_res_cnt <= n_res_cnt;
        r_out     <= n_out;
    end

endmodule

`default_nettype wire

// ===== verif/prmt_match_checker.sv =====
`timescale 1ns / 1ps
// Checker for the pending response match table: watches the command, config and
// result channels, keeps its own copy of the slot table and compares every beat.
// Depends on prmt_pkg.
module prmt_match_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    input  wire logic                            i_in_stall,
    input  wire logic [prmt_pkg::CMD_W-1:0]      i_cmd,
    input  wire logic [prmt_pkg::HANDLE_W-1:0]   i_owner_handle,
    input  wire logic [prmt_pkg::SEQ_W-1:0]      i_seq_num,
    input  wire logic [prmt_pkg::TYPE_W-1:0]     i_pkt_type,
    input  wire logic [prmt_pkg::REMOTE_W-1:0]   i_remote_addr,
    input  wire logic [prmt_pkg::TIME_W-1:0]     i_deadline,
    input  wire logic [prmt_pkg::TIME_W-1:0]     i_now_time,
    input  wire logic                            i_cfg_valid,
    input  wire logic                            i_cfg_ready,
    input  wire logic [prmt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [prmt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_out_valid,
    input  wire logic                            i_out_stall,
    input  wire logic [prmt_pkg::EVENT_W-1:0]    i_event_res,
    input  wire logic [prmt_pkg::HANDLE_W-1:0]   i_out_handle,
    input  wire logic [prmt_pkg::SEQ_W-1:0]      i_out_seq,
    input  wire logic [prmt_pkg::REMOTE_W-1:0]   i_out_remote,
    input  wire logic [prmt_pkg::OUT_SLOT_W-1:0] i_out_slot,
    input  wire logic [prmt_pkg::REMOVED_W-1:0]  i_removed_count,
    input  wire logic                            i_last,
    output int                                   o_fail_count,
    output int                                   o_outstanding,
    output int                                   o_beats_checked
);
    import prmt_pkg::*;

    logic [HANDLE_W-1:0] tbl_owner  [SLOTS];
    logic [SEQ_W-1:0]    tbl_seq    [SLOTS];
    logic [TYPE_W-1:0]   tbl_type   [SLOTS];
    logic [REMOTE_W-1:0] tbl_remote [SLOTS];
    logic [TIME_W-1:0]   tbl_expiry [SLOTS];
    logic [TIME_W-1:0]   last_sweep_at;
    logic [TIME_W-1:0]   sweep_period;
    logic [TYPE_W-1:0]   nack_code;

    t_result awaited_beats[$];

    initial begin
        o_fail_count    = 0;
        o_outstanding   = 0;
        o_beats_checked = 0;
    end

    function automatic t_result make_beat(input t_event ev, input logic [HANDLE_W-1:0] h,
                                          input logic [SEQ_W-1:0] s,
                                          input logic [REMOTE_W-1:0] r,
                                          input int slot, input int removed);
        t_result b;
        b           = '0;
        b.event_res = ev;
        b.handle    = h;
        b.seq       = s;
        b.remote    = r;
        b.slot      = OUT_SLOT_W'(slot);
        b.removed   = (removed > 15) ? REMOVED_MAX : REMOVED_W'(removed);
        b.last      = 1'b0;
        return b;
    endfunction

    task automatic clear_entry(input int i);
        tbl_owner[i]  = '0;
        tbl_seq[i]    = '0;
        tbl_type[i]   = '0;
        tbl_remote[i] = '0;
        tbl_expiry[i] = '0;
    endtask

    task automatic apply_command(input logic [CMD_W-1:0] cmd,
                                 input logic [HANDLE_W-1:0] hnd,
                                 input logic [SEQ_W-1:0] seq,
                                 input logic [TYPE_W-1:0] ptype,
                                 input logic [REMOTE_W-1:0] remote,
                                 input logic [TIME_W-1:0] dl,
                                 input logic [TIME_W-1:0] now);
        t_result           beats[$];
        t_result           b;
        int                free_idx;
        int                removed;
        logic              any_valid;
        logic [TIME_W-1:0] since_sweep;
        t_event            hit_ev;
        free_idx    = -1;
        removed     = 0;
        any_valid   = 1'b0;
        since_sweep = now - last_sweep_at;
        hit_ev      = (ptype == nack_code) ? EV_NACK_FAIL : EV_DELIVER;
        case (cmd)
            CMD_REGISTER: begin
                if (hnd != '0) begin
                    for (int i = SLOTS - 1; i >= 0; i--) begin
                        if (tbl_owner[i] == '0) begin
                            free_idx = i;
                        end
                    end
                end
                if (free_idx < 0) begin
                    beats.push_back(make_beat(EV_REG_REFUSED, hnd, '0, '0, 0, 0));
                end else begin
                    tbl_owner[free_idx]  = hnd;
                    tbl_seq[free_idx]    = seq;
                    tbl_type[free_idx]   = ptype;
                    tbl_remote[free_idx] = remote;
                    tbl_expiry[free_idx] = dl;
                    beats.push_back(make_beat(EV_REG_OK, hnd, '0, '0, free_idx, 0));
                end
            end
            CMD_RESPONSE: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (tbl_owner[i] != '0 && (tbl_type[i] == ptype || tbl_seq[i] == seq) &&
                        (tbl_remote[i] == remote || tbl_remote[i] == '0) &&
                        beats.size() < MAX_RES) begin
                        beats.push_back(make_beat(hit_ev, tbl_owner[i], seq, remote, i, 0));
                    end
                end
                if (beats.size() == 0) begin
                    beats.push_back(make_beat(EV_NO_MATCH, '0, '0, '0, 0, 0));
                end
            end
            CMD_TICK: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (tbl_owner[i] != '0) begin
                        any_valid = 1'b1;
                    end
                end
                if (any_valid && now > sweep_period && since_sweep > sweep_period) begin
                    last_sweep_at = now;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (tbl_owner[i] != '0 && tbl_expiry[i] != '0 && tbl_expiry[i] < now) begin
                            if (beats.size() < MAX_RES) begin
                                beats.push_back(make_beat(EV_TIMEOUT, tbl_owner[i], tbl_seq[i],
                                                          tbl_remote[i], i, 0));
                            end
                            clear_entry(i);
                        end
                    end
                end
                if (beats.size() == 0) begin
                    beats.push_back(make_beat(EV_TICK_DONE, '0, '0, '0, 0, 0));
                end
            end
            default: begin
                if (hnd != '0) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (tbl_owner[i] == hnd) begin
                            clear_entry(i);
                            removed++;
                        end
                    end
                end
                beats.push_back(make_beat((removed != 0) ? EV_UNREG_DONE : EV_UNREG_NONE,
                                          hnd, '0, '0, 0, removed));
            end
        endcase
        for (int k = 0; k < beats.size(); k++) begin
            b      = beats[k];
            b.last = (k == beats.size() - 1);
            awaited_beats.push_back(b);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                clear_entry(i);
            end
            last_sweep_at = '0;
            sweep_period  = PERIOD_RESET;
            nack_code     = NACK_RESET;
            awaited_beats.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                o_beats_checked++;
                if (awaited_beats.size() == 0) begin
                    $error("result beat with nothing awaited: event_res %0h", i_event_res);
                    o_fail_count++;
                end else begin
                    want = awaited_beats.pop_front();
                    check_field("event_res", want.event_res, i_event_res);
                    check_field("out_handle", want.handle, i_out_handle);
                    check_field("out_seq", want.seq, i_out_seq);
                    check_field("out_remote", want.remote, i_out_remote);
                    check_field("out_slot", want.slot, i_out_slot);
                    check_field("removed_count", want.removed, i_removed_count);
                    check_field("last", want.last, i_last);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_IDX_PERIOD: sweep_period = i_cfg_data[TIME_W-1:0];
                    CFG_IDX_NACK:   nack_code = i_cfg_data[TYPE_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                apply_command(i_cmd, i_owner_handle, i_seq_num, i_pkt_type, i_remote_addr,
                              i_deadline, i_now_time);
            end
        end
        o_outstanding = awaited_beats.size();
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the pending response match table: drives commands, config
// writes and result stalls, and gives the verdict from the checker's counts.
// Depends on prmt_pkg, pending_response_match_table_unit and prmt_match_checker.
module tb_top;
    import prmt_pkg::*;

    localparam int HIST = 8;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_in_valid      = 1'b0;
    logic                  o_in_stall;
    logic [CMD_W-1:0]      i_cmd           = '0;
    logic [HANDLE_W-1:0]   i_owner_handle  = '0;
    logic [SEQ_W-1:0]      i_seq_num       = '0;
    logic [TYPE_W-1:0]     i_pkt_type      = '0;
    logic [REMOTE_W-1:0]   i_remote_addr   = '0;
    logic [TIME_W-1:0]     i_deadline      = '0;
    logic [TIME_W-1:0]     i_now_time      = '0;
    logic                  i_cfg_valid     = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                  o_out_valid;
    logic                  i_out_stall     = 1'b0;
    logic [EVENT_W-1:0]    o_event_res;
    logic [HANDLE_W-1:0]   o_out_handle;
    logic [SEQ_W-1:0]      o_out_seq;
    logic [REMOTE_W-1:0]   o_out_remote;
    logic [OUT_SLOT_W-1:0] o_out_slot;
    logic [REMOVED_W-1:0]  o_removed_count;
    logic                  o_last;

    int fail_count;
    int outstanding;
    int beats_checked;

    int in_gap_max    = 5;
    int out_stall_max = 5;
    int n_commands    = 0;
    int n_writes      = 0;

    logic [TYPE_W-1:0]   cur_nack = NACK_RESET;
    logic [TIME_W-1:0]   sim_now  = '0;
    logic [SEQ_W-1:0]    hist_seq    [HIST];
    logic [TYPE_W-1:0]   hist_type   [HIST];
    logic [REMOTE_W-1:0] hist_remote [HIST];
    int                  hist_idx = 0;

    pending_response_match_table_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_cmd           (i_cmd),
        .i_owner_handle  (i_owner_handle),
        .i_seq_num       (i_seq_num),
        .i_pkt_type      (i_pkt_type),
        .i_remote_addr   (i_remote_addr),
        .i_deadline      (i_deadline),
        .i_now_time      (i_now_time),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_event_res     (o_event_res),
        .o_out_handle    (o_out_handle),
        .o_out_seq       (o_out_seq),
        .o_out_remote    (o_out_remote),
        .o_out_slot      (o_out_slot),
        .o_removed_count (o_removed_count),
        .o_last          (o_last)
    );

    prmt_match_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_cmd           (i_cmd),
        .i_owner_handle  (i_owner_handle),
        .i_seq_num       (i_seq_num),
        .i_pkt_type      (i_pkt_type),
        .i_remote_addr   (i_remote_addr),
        .i_deadline      (i_deadline),
        .i_now_time      (i_now_time),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_event_res     (o_event_res),
        .i_out_handle    (o_out_handle),
        .i_out_seq       (o_out_seq),
        .i_out_remote    (o_out_remote),
        .i_out_slot      (o_out_slot),
        .i_removed_count (o_removed_count),
        .i_last          (o_last),
        .o_fail_count    (fail_count),
        .o_outstanding   (outstanding),
        .o_beats_checked (beats_checked)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    task automatic drive_command(input logic [CMD_W-1:0] cmd,
                                 input logic [HANDLE_W-1:0] hnd,
                                 input logic [SEQ_W-1:0] seq,
                                 input logic [TYPE_W-1:0] ptype,
                                 input logic [REMOTE_W-1:0] remote,
                                 input logic [TIME_W-1:0] dl,
                                 input logic [TIME_W-1:0] now);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_cmd          <= cmd;
        i_owner_handle <= hnd;
        i_seq_num      <= seq;
        i_pkt_type     <= ptype;
        i_remote_addr  <= remote;
        i_deadline     <= dl;
        i_now_time     <= now;
        do @(posedge i_clk); while (o_in_stall);
        n_commands++;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        n_writes++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
    endtask

    task automatic drive_random_command();
        logic [CMD_W-1:0]    cmd;
        logic [HANDLE_W-1:0] hnd;
        logic [SEQ_W-1:0]    seq;
        logic [TYPE_W-1:0]   ptype;
        logic [REMOTE_W-1:0] remote;
        logic [TIME_W-1:0]   dl;
        logic [TIME_W-1:0]   now;
        int                  pick;
        int                  h;
        seq    = $urandom;
        ptype  = $urandom;
        remote = $urandom;
        dl     = $urandom;
        now    = $urandom;
        hnd    = $urandom_range(1, 6);
        if ($urandom_range(0, 9) == 0) begin
            hnd = $urandom;
        end
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            cmd = CMD_REGISTER;
            if ($urandom_range(0, 3) != 0) begin
                seq   = $urandom_range(0, 7);
                ptype = $urandom_range(1, 4);
            end
            case ($urandom_range(0, 3))
                0:       remote = '0;
                1, 2:    remote = $urandom_range(1, 3);
                default: ;
            endcase
            case ($urandom_range(0, 9))
                0, 1:    dl = '0;
                2:       ;
                default: dl = sim_now + $urandom_range(1, 4000);
            endcase
            hist_seq[hist_idx]    = seq;
            hist_type[hist_idx]   = ptype;
            hist_remote[hist_idx] = remote;
            hist_idx              = (hist_idx + 1) % HIST;
        end else if (pick < 65) begin
            cmd = CMD_RESPONSE;
            h   = $urandom_range(0, HIST - 1);
            if ($urandom_range(0, 9) < 7) begin
                seq    = hist_seq[h];
                ptype  = hist_type[h];
                remote = hist_remote[h];
                case ($urandom_range(0, 3))
                    0:       seq = $urandom;
                    1:       ptype = $urandom;
                    2:       remote = $urandom_range(1, 3);
                    default: ;
                endcase
            end
            if ($urandom_range(0, 4) == 0) begin
                ptype = cur_nack;
            end
        end else if (pick < 82) begin
            cmd     = CMD_TICK;
            sim_now = sim_now + $urandom_range(0, 1500);
            if ($urandom_range(0, 9) != 0) begin
                now = sim_now;
            end
        end else begin
            cmd = CMD_UNREGISTER;
        end
        drive_command(cmd, hnd, seq, ptype, remote, dl, now);
    endtask

    initial begin : result_sink
        int stall_cycles;
        forever begin
            @(negedge i_clk);
            stall_cycles = $urandom_range(0, out_stall_max);
            if (stall_cycles != 0) begin
                i_out_stall <= 1'b1;
                repeat (stall_cycles) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin : stimulus
        logic [TIME_W-1:0] period_val;
        logic [TYPE_W-1:0] nack_val;
        int                n_directed;
        for (int i = 0; i < HIST; i++) begin
            hist_seq[i]    = '0;
            hist_type[i]   = '0;
            hist_remote[i] = '0;
        end
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // refused handle, empty table, sweep skipped on an empty table
        drive_command(CMD_REGISTER, 8'd0, 16'h1234, 8'h11, 16'h0042, 32'd500, 32'd0);
        drive_command(CMD_UNREGISTER, 8'd5, 16'h0, 8'h0, 16'h0, 32'd0, 32'd0);
        drive_command(CMD_TICK, 8'd0, 16'h0, 8'h0, 16'h0, 32'd0, 32'd5000);
        drive_command(CMD_RESPONSE, 8'd0, 16'h0, 8'h0, 16'h0, 32'd0, 32'd0);
        // fill all slots, then overflow
        drive_command(CMD_REGISTER, 8'd1, 16'h0001, 8'h10, 16'h0000, 32'd1500, 32'd0);
        drive_command(CMD_REGISTER, 8'd2, 16'hFFFF, 8'hFF, 16'hFFFF, 32'd0, 32'hFFFF_FFFF);
        drive_command(CMD_REGISTER, 8'd3, 16'h0002, 8'h10, 16'h0007, 32'd2000, 32'd0);
        drive_command(CMD_REGISTER, 8'd1, 16'h0003, 8'h20, 16'h0007, 32'hFFFF_FFFF, 32'd0);
        drive_command(CMD_REGISTER, 8'd255, 16'h0004, 8'h30, 16'h0000, 32'd1999, 32'd0);
        drive_command(CMD_REGISTER, 8'd1, 16'h0005, 8'h10, 16'h0008, 32'd0, 32'd0);
        drive_command(CMD_REGISTER, 8'd4, 16'h0001, 8'h40, 16'h0007, 32'd0, 32'd0);
        drive_command(CMD_REGISTER, 8'd6, 16'h8000, 8'h80, 16'h8000, 32'd3000, 32'd0);
        drive_command(CMD_REGISTER, 8'd7, 16'h0009, 8'h09, 16'h0009, 32'd10, 32'd0);
        // nack, multi-deliver, wildcard remote
        drive_command(CMD_RESPONSE, 8'd0, 16'h0001, 8'hFF, 16'h0007, 32'd0, 32'd0);
        drive_command(CMD_RESPONSE, 8'd0, 16'h0009, 8'h10, 16'h0007, 32'd0, 32'd0);
        drive_command(CMD_RESPONSE, 8'd0, 16'hFFFF, 8'h00, 16'hFFFF, 32'd0, 32'd0);
        drive_command(CMD_RESPONSE, 8'd0, 16'h0004, 8'h30, 16'h1234, 32'd0, 32'd0);
        // time not past period, sweep, sweep too soon, sweep at max time
        drive_command(CMD_TICK, 8'd0, 16'h0, 8'h0, 16'h0, 32'd0, 32'd900);
        drive_command(CMD_TICK, 8'd0, 16'h0, 8'h0, 16'h0, 32'd0, 32'd2000);
        drive_command(CMD_TICK, 8'd0, 16'h0, 8'h0, 16'h0, 32'd0, 32'd2500);
        drive_command(CMD_UNREGISTER, 8'd1, 16'h0, 8'h0, 16'h0, 32'd0, 32'd0);
        drive_command(CMD_UNREGISTER, 8'd0, 16'h0, 8'h0, 16'h0, 32'd0, 32'd0);
        drive_command(CMD_TICK, 8'd0, 16'h0, 8'h0, 16'h0, 32'd0, 32'hFFFF_FFFF);
        n_directed = n_commands;

        for (int phase = 0; phase < 4; phase++) begin
            wait_idle();
            case (phase)
                0: begin
                    period_val = '0;
                    nack_val   = '0;
                end
                1: begin
                    period_val = 32'hFFFF_FFFF;
                    nack_val   = 8'hA5;
                end
                2: begin
                    period_val = $urandom_range(1, 5000);
                    nack_val   = $urandom;
                end
                default: begin
                    period_val = PERIOD_RESET;
                    nack_val   = NACK_RESET;
                end
            endcase
            write_register(CFG_IDX_PERIOD, period_val);
            write_register(CFG_IDX_NACK, CFG_DATA_W'(nack_val));
            cur_nack      = nack_val;
            sim_now       = $urandom_range(0, 5000);
            in_gap_max    = (phase == 1 || phase == 3) ? 0 : 5;
            out_stall_max = (phase == 1 || phase == 2) ? 0 : 5;
            repeat (34) drive_random_command();
        end

        wait_idle();
        repeat (30) @(negedge i_clk);
        $display("Drove %0d commands (%0d directed) across %0d register writes;",
                 n_commands, n_directed, n_writes);
        $display("compared %0d result beats against the predicted slot table.", beats_checked);
        if (fail_count == 0 && outstanding == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin : watchdog
        #(5_000_000);
        $display("FAILURE");
        $finish;
    end

endmodule
